FILE: rtl/frti_pkg.sv
// Package for the float round-to-integral block: mode codes, constants and
// the combinational rounding function. No dependencies.
`default_nettype none
package frti_pkg;

  typedef logic [1:0]  mode_t;
  typedef logic [31:0] fbits_t;

  localparam mode_t MODE_TRUNC = 2'd0;
  localparam mode_t MODE_CEIL  = 2'd1;
  localparam mode_t MODE_FLOOR = 2'd2;
  localparam mode_t MODE_ROUND = 2'd3;

  localparam int unsigned FracBits = 23;
  localparam logic [7:0] IntExp  = 8'd150;
  localparam logic [7:0] HalfExp = 8'd126;
  localparam fbits_t SignBit = 32'h8000_0000;
  localparam fbits_t OnePos  = 32'h3F80_0000;
  localparam fbits_t OneNeg  = 32'hBF80_0000;
  localparam logic [23:0] RndMask = 24'hFF_FFFF;
  localparam logic [23:0] RndUnit = 24'h80_0000;

  function automatic fbits_t round_bits(mode_t mode, fbits_t x);
    logic        sgn;
    logic [30:0] mag;
    logic [7:0]  e;
    logic [4:0]  sh_r;
    logic [4:0]  sh_t;
    logic [30:0] m;
    logic [30:0] sum;
    logic [30:0] lostm;
    logic        up;
    fbits_t      res;
    sgn   = x[31];
    mag   = x[30:0];
    e     = x[30:23];
    sh_r  = 5'(e - HalfExp);
    sh_t  = 5'(IntExp - e);
    m     = {7'd0, RndMask >> sh_r};
    if (sh_r == 5'd0) m = m >> 1;
    sum   = mag + {7'd0, RndUnit >> sh_r};
    lostm = (31'd1 << sh_t) - 31'd1;
    up    = ((mag & lostm) != 31'd0) &&
            (((mode == MODE_CEIL) && !sgn) || ((mode == MODE_FLOOR) && sgn));
    if (e >= IntExp) begin
      res = x;
    end else if (mode == MODE_ROUND) begin
      if (e < HalfExp) res = {sgn, 31'd0};
      else             res = {sgn, sum & ~m};
    end else if (e < 8'(IntExp - FracBits)) begin
      case (mode)
        MODE_CEIL:  res = sgn ? SignBit : ((mag != 31'd0) ? OnePos : 32'd0);
        MODE_FLOOR: res = (sgn && (mag != 31'd0)) ? OneNeg : {sgn, 31'd0};
        default:    res = {sgn, 31'd0};
      endcase
    end else begin
      res = {sgn, ((mag & ~lostm) + (up ? (31'd1 << sh_t) : 31'd0))};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/frti_if.sv
// Valid/ready channel interfaces for the rounding block.
// Depends on frti_pkg.
`default_nettype none
interface frti_in_if (input wire logic clk);
  logic               valid;
  logic               ready;
  frti_pkg::mode_t    mode;
  frti_pkg::fbits_t   value_bits;
  modport source (output valid, mode, value_bits, input ready);
  modport sink   (input valid, mode, value_bits, output ready);
endinterface

interface frti_out_if (input wire logic clk);
  logic               valid;
  logic               ready;
  frti_pkg::fbits_t   result_bits;
  modport source (output valid, result_bits, input ready);
  modport sink   (input valid, result_bits, output ready);
endinterface
`default_nettype wire

FILE: rtl/float_round_to_integral.sv
// Top level of the float round-to-integral unit: input register, rounding
// logic, result register. Depends on frti_pkg and frti_if.
//
//   channel | dir | payload
//   in_     | in  | mode, value_bits
//   out_    | out | result_bits
//
// One transaction per cycle unless the result side stalls; input register
// then result register. Round logic: shifts, masks and 31-bit adds.
// Synchronous active-low reset clears both valid flags.
// Stall: each stage advances when it is empty or its content is taken downstream.
`default_nettype none
module float_round_to_integral (
  input  wire logic clk,
  input  wire logic rst_n,
  frti_in_if.sink   in_ch,
  frti_out_if.source out_ch
);
  import frti_pkg::*;

  logic   s1_vld_r;
  mode_t  s1_mode_r;
  fbits_t s1_val_r;
  logic   o_vld_r;
  fbits_t o_res_r;
  logic   o_adv;
  logic   s1_adv;

  assign o_adv  = !o_vld_r || out_ch.ready;
  assign s1_adv = !s1_vld_r || o_adv;
  assign in_ch.ready = s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      o_vld_r  <= 1'b0;
    end else begin
      if (s1_adv) s1_vld_r <= in_ch.valid;
      if (o_adv)  o_vld_r  <= s1_vld_r;
    end
    if (s1_adv && in_ch.valid) begin
      s1_mode_r <= in_ch.mode;
      s1_val_r  <= in_ch.value_bits;
    end
    if (o_adv && s1_vld_r) o_res_r <= round_bits(s1_mode_r, s1_val_r);
  end

  assign out_ch.valid       = o_vld_r;
  assign out_ch.result_bits = o_res_r;
endmodule
`default_nettype wire

FILE: rtl/frti_checker.sv
// Port-level checker for float_round_to_integral, bound to the top level.
// Depends on frti_pkg and frti_if.
`default_nettype none
module frti_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [31:0] out_result_bits
);
  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_bits))
    else $error("result changed while stalled");
  // an accepted transaction reaches the output via the input and result registers when nothing stalls
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready ##1 out_ready ##0 1'b1 |-> ##1 out_valid)
    else $error("result missing");
  // ready is up whenever the output is free
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input blocked with free output");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");
endmodule

bind float_round_to_integral frti_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_result_bits(out_ch.result_bits)
);
`default_nettype wire

FILE: sim/tb_round_sb.sv
// Result checker for the float round-to-integral testbench: predicts each
// rounded value from the accepted operand and compares it. Depends on frti_pkg.
`timescale 1ns / 100ps

class round_scoreboard;
  frti_pkg::fbits_t pending_q[$];
  int unsigned      errors;
  int unsigned      checked;

  function new();
    errors  = 0;
    checked = 0;
  endfunction

  // Round on the bit pattern: mask fraction bits and bump at the integer position.
  static function frti_pkg::fbits_t predict_round(frti_pkg::mode_t md, frti_pkg::fbits_t x);
    logic [31:0] sgn;
    logic [31:0] mag;
    int unsigned ex;
    int unsigned sh;
    logic [31:0] msk;
    logic [31:0] q;
    sgn = x & 32'h8000_0000;
    mag = x & 32'h7FFF_FFFF;
    ex  = mag[30:23];
    if (ex >= 150) return x;
    if (md == frti_pkg::MODE_ROUND) begin
      if (ex < 126) return sgn;
      sh  = ex - 126;
      msk = 32'h00FF_FFFF >> sh;
      if (sh == 0) msk = msk >> 1;
      mag = (mag + (32'h0080_0000 >> sh)) & ~msk;
      return sgn | (mag & 32'h7FFF_FFFF);
    end
    sh = 150 - ex;
    if (sh > 23) begin
      if (md == frti_pkg::MODE_CEIL) begin
        if (sgn != 0) return 32'h8000_0000;
        return (mag != 0) ? 32'h3F80_0000 : 32'h0;
      end
      if (md == frti_pkg::MODE_FLOOR) begin
        if (sgn != 0 && mag != 0) return 32'hBF80_0000;
        return sgn;
      end
      return sgn;
    end
    q = mag >> sh;
    if ((mag & ((32'd1 << sh) - 1)) != 0) begin
      if ((md == frti_pkg::MODE_CEIL && sgn == 0) ||
          (md == frti_pkg::MODE_FLOOR && sgn != 0)) q = q + 1;
    end
    return sgn | ((q << sh) & 32'h7FFF_FFFF);
  endfunction

  function void note_operand(frti_pkg::mode_t md, frti_pkg::fbits_t x);
    pending_q.push_back(predict_round(md, x));
  endfunction

  task check_result(frti_pkg::fbits_t got);
    frti_pkg::fbits_t want;
    checked++;
    if (pending_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result %08h", got));
      return;
    end
    want = pending_q.pop_front();
    if (got !== want)
      report_mismatch($sformatf("result_bits %08h, predicted %08h", got, want));
  endtask

  task report_mismatch(string msg);
    errors++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask
endclass

FILE: sim/tb.sv
// Top of the float round-to-integral testbench: drives operands with random
// idling, stalls the result side, checks results through round_scoreboard.
`timescale 1ns / 100ps

module tb;
  import frti_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  frti_in_if  in_ch (clk);
  frti_out_if out_ch (clk);

  float_round_to_integral u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  round_scoreboard sb = new();
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int sent;

  // Offer one operand; hold it until the block takes it.
  task automatic send_operand(mode_t md, fbits_t x);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= md;
    in_ch.value_bits <= x;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_operand(md, x);
    sent++;
  endtask

  // Random operand, biased toward the interesting exponent band.
  task automatic send_random();
    fbits_t x;
    logic [7:0] ex;
    x = $urandom;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: ex = 8'($urandom_range(151, 115));
      5:             ex = 8'($urandom_range(255, 250));
      6:             ex = 8'($urandom_range(1)) * 8'd255;
      default:       ex = x[30:23];
    endcase
    x[30:23] = ex;
    if ($urandom_range(7) == 0) x[22:0] = '0;
    send_operand(mode_t'($urandom_range(3)), x);
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic wait_drained();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (sb.pending_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  // Result side: stall at random, or hold off for a counted stretch.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.result_bits);
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles  <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    fbits_t edges[$];
    int ph;
    in_ch.valid      = 1'b0;
    in_ch.mode       = MODE_TRUNC;
    in_ch.value_bits = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    sent           = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    edges = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h8000_0001,
              32'h3F00_0000, 32'hBF00_0000, 32'h3EFF_FFFF, 32'h3FC0_0000,
              32'hBFC0_0000, 32'h4B00_0000, 32'h4AFF_FFFF, 32'hCAFF_FFFF,
              32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001, 32'hFFFF_FFFF,
              32'h7FFF_FFFF, 32'h3F7F_FFFF, 32'h4040_0000, 32'h3F80_0001};
    foreach (edges[i]) send_operand(mode_t'(i % 4), edges[i]);
    foreach (edges[i]) if (i < 5) send_operand(mode_t'((i + 2) % 4), edges[i]);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      repeat (190) send_random();
      if (ph == 1) wait_drained();
    end

    // Long result hold-off while operands keep coming, so the input backs up.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 40;
    repeat (20) send_random();
    wait_drained();

    $display("Covered %0d operands in all four modes over four idling phases,", sent);
    $display("plus a long result hold-off; %0d results checked.", sb.checked);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

FILE: float_round_to_integral.f
rtl/frti_pkg.sv
rtl/frti_if.sv
rtl/float_round_to_integral.sv
rtl/frti_checker.sv
sim/tb_round_sb.sv
sim/tb.sv
